[sv/connection_timing_wheel_assert.svh]
// Assertion macros used by the timing wheel checker.
`ifndef CONNECTION_TIMING_WHEEL_ASSERT_SVH
`define CONNECTION_TIMING_WHEEL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CTW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timing wheel check failed");

// Next-cycle implication, disabled during reset.
`define CTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timing wheel check failed");

`endif

[sv/ctw_pkg.sv]
// Shared constants, codes and types of the connection timing wheel.
`timescale 1ns / 1ps
package ctw_pkg;

   localparam int MAX_CONNS     = 64;
   localparam int MAX_SLOTS     = 64;
   localparam int DEFAULT_SLOTS = 60;

   localparam int ID_W    = $clog2(MAX_CONNS);
   localparam int HOME_W  = $clog2(MAX_SLOTS);
   localparam int SLOTS_W = 7;
   localparam int TIME_W  = 16;

   // Operation codes of an input word.
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ARM    = 2'd1;
   localparam logic [1:0] OP_DISARM = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_ACCEPT  = 2'd0;
   localparam logic [1:0] KIND_REJECT  = 2'd1;
   localparam logic [1:0] KIND_EXPIRED = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   // One timer entry of the wheel memory.
   typedef struct packed {
      logic [HOME_W-1:0] home;
      logic [TIME_W-1:0] rounds;
   } entry_type;

   // Divider request and response.
   typedef struct packed {
      logic              start;
      logic [TIME_W-1:0] dividend;
      logic [SLOTS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [TIME_W-1:0]  quotient;
      logic [SLOTS_W-1:0] remainder;
   } div_rsp_type;

   // Slot count in use: zero means the default, large values saturate.
   function automatic logic [SLOTS_W-1:0] slots_in_use(input logic [SLOTS_W-1:0] raw);
      logic [SLOTS_W-1:0] s;
      s = raw;
      if (raw == '0) begin
         s = SLOTS_W'(DEFAULT_SLOTS);
      end else if (raw > SLOTS_W'(MAX_SLOTS)) begin
         s = SLOTS_W'(MAX_SLOTS);
      end
      return s;
   endfunction

endpackage

[sv/ctw_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module ctw_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ctw_div.sv]
// Restoring divider: one quotient bit per cycle, by a slot count divisor.
`timescale 1ns / 1ps
module ctw_div import ctw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(TIME_W);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [SLOTS_W-1:0]  div_ff;
   logic [SLOTS_W-1:0]  rem_ff;
   logic [TIME_W-1:0]   quo_ff;
   logic [SLOTS_W:0]    shifted;
   logic [SLOTS_W:0]    diff;
   logic                fits;

   // Trial subtraction of the divisor from the shifted partial remainder.
   always_comb begin
      shifted = {rem_ff, quo_ff[TIME_W-1]};
      diff    = shifted - {1'b0, div_ff};
      fits    = shifted >= {1'b0, div_ff};
   end

   // Control of the iteration.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TIME_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: the dividend shifts out of the quotient register as bits come in.
   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         div_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[TIME_W-2:0], fits};
         rem_ff <= fits ? diff[SLOTS_W-1:0] : shifted[SLOTS_W-1:0];
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

[sv/connection_timing_wheel.sv]
// Tick: a divide steps the current slot, a scan checks every connection, then the last word; plus stalls.
// Arm: its word follows two divides that place the timer; a zero timeout is rejected without a divide.
// Disarm and other words: the word is registered from the result state once the output is free.
// One input word at a time; the next is taken the cycle after the final word is registered.
// Reset clears the armed bits and the current slot and loads 60 slots; timer memory keeps data.
`timescale 1ns / 1ps
module connection_timing_wheel import ctw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [ID_W-1:0]    req_conn_id,
   input  logic [TIME_W-1:0]  req_timeout,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [ID_W-1:0]    rsp_expired_id,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [SLOTS_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK_DIV,
      S_SCAN,
      S_TICK_END,
      S_ARM_DIV1,
      S_ARM_DIV2,
      S_RESULT
   } state_type;

   state_type           state_ff;
   logic [SLOTS_W-1:0]  wheel_slots_ff;
   logic [MAX_CONNS-1:0] armed_ff;
   logic [HOME_W-1:0]   cur_ff;
   logic [ID_W-1:0]     id_ff;
   logic [TIME_W-1:0]   rounds_ff;
   logic [1:0]          res_kind_ff;
   logic [ID_W:0]       iss_idx_ff;
   logic                chk_valid_ff;
   logic [ID_W-1:0]     chk_idx_ff;
   logic                pend_valid_ff;
   logic [ID_W-1:0]     pend_id_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_kind_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic                rsp_last_ff;
   div_req_type         div_req_ff;
   div_rsp_type         div_rsp;

   logic [SLOTS_W-1:0]  slots;
   logic                out_free;
   entry_type           rd_entry;
   logic [$bits(entry_type)-1:0] ram_rdata;
   logic                hit;
   logic                expire;
   logic                decr;
   logic                stall;
   logic                mem_we;
   logic [ID_W-1:0]     mem_waddr;
   entry_type           mem_wdata;
   logic [ID_W-1:0]     mem_raddr;

   // Divider shared by slot stepping and timer placement.
   ctw_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   // Timer memory: home slot and rounds left per connection.
   ctw_ram #(
      .DATA_W ($bits(entry_type)),
      .ADDR_W (ID_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (ram_rdata)
   );

   // Scan stage decisions on the entry read in the previous cycle.
   always_comb begin
      slots    = slots_in_use(wheel_slots_ff);
      out_free = !rsp_valid_ff || rsp_ready;
      rd_entry = entry_type'(ram_rdata);
      hit      = (state_ff == S_SCAN) && chk_valid_ff && armed_ff[chk_idx_ff] &&
                 (rd_entry.home == cur_ff);
      expire   = hit && (rd_entry.rounds == '0);
      decr     = hit && (rd_entry.rounds != '0);
      stall    = expire && pend_valid_ff && !out_free;
      mem_raddr = stall ? chk_idx_ff : iss_idx_ff[ID_W-1:0];
   end

   // Memory write: a decrement during the scan or a new timer at the end of an arm.
   always_comb begin
      mem_we           = 1'b0;
      mem_waddr        = chk_idx_ff;
      mem_wdata.home   = rd_entry.home;
      mem_wdata.rounds = rd_entry.rounds - 1'b1;
      if (decr) begin
         mem_we = 1'b1;
      end else if ((state_ff == S_ARM_DIV2) && div_rsp.done) begin
         mem_we           = 1'b1;
         mem_waddr        = id_ff;
         mem_wdata.home   = div_rsp.remainder[HOME_W-1:0];
         mem_wdata.rounds = rounds_ff;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_slots_ff <= SLOTS_W'(DEFAULT_SLOTS);
      end else if (csr_wr_en) begin
         wheel_slots_ff <= csr_wr_data;
      end
   end

   // Sequencer with the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         armed_ff         <= '0;
         cur_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         pend_valid_ff    <= 1'b0;
         chk_valid_ff     <= 1'b0;
         iss_idx_ff       <= '0;
         div_req_ff.start <= 1'b0;
      end else begin
         div_req_ff.start <= 1'b0;
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  id_ff <= req_conn_id;
                  res_kind_ff <= KIND_ACCEPT;
                  priority if (req_operation == OP_TICK) begin
                     div_req_ff.start    <= 1'b1;
                     div_req_ff.dividend <= TIME_W'(cur_ff) + 1'b1;
                     div_req_ff.divisor  <= slots;
                     state_ff            <= S_TICK_DIV;
                  end else if (req_operation == OP_ARM) begin
                     if (req_timeout == '0) begin
                        res_kind_ff <= KIND_REJECT;
                        state_ff    <= S_RESULT;
                     end else begin
                        div_req_ff.start    <= 1'b1;
                        div_req_ff.dividend <= req_timeout - 1'b1;
                        div_req_ff.divisor  <= slots;
                        state_ff            <= S_ARM_DIV1;
                     end
                  end else if (req_operation == OP_DISARM) begin
                     armed_ff[req_conn_id] <= 1'b0;
                     state_ff              <= S_RESULT;
                  end else begin
                     state_ff <= S_RESULT;
                  end
               end
            end
            S_TICK_DIV: begin
               if (div_rsp.done) begin
                  cur_ff        <= div_rsp.remainder[HOME_W-1:0];
                  iss_idx_ff    <= '0;
                  chk_valid_ff  <= 1'b0;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (!stall) begin
                  // An expiry is held back one step so the final one can carry last.
                  if (expire) begin
                     armed_ff[chk_idx_ff] <= 1'b0;
                     pend_valid_ff        <= 1'b1;
                     pend_id_ff           <= chk_idx_ff;
                     if (pend_valid_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_kind_ff  <= KIND_EXPIRED;
                        rsp_id_ff    <= pend_id_ff;
                        rsp_last_ff  <= 1'b0;
                     end
                  end
                  chk_valid_ff <= !iss_idx_ff[ID_W];
                  chk_idx_ff   <= iss_idx_ff[ID_W-1:0];
                  if (iss_idx_ff[ID_W]) begin
                     state_ff <= S_TICK_END;
                  end else begin
                     iss_idx_ff <= iss_idx_ff + 1'b1;
                  end
               end
            end
            S_TICK_END: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= pend_valid_ff ? KIND_EXPIRED : KIND_NONE;
                  rsp_id_ff     <= pend_valid_ff ? pend_id_ff : '0;
                  rsp_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  chk_valid_ff  <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            S_ARM_DIV1: begin
               // The remainder of timeout-1 gives the slot offset less one.
               if (div_rsp.done) begin
                  rounds_ff           <= div_rsp.quotient;
                  div_req_ff.start    <= 1'b1;
                  div_req_ff.dividend <= TIME_W'(cur_ff) + TIME_W'(div_rsp.remainder) + 1'b1;
                  div_req_ff.divisor  <= slots;
                  state_ff            <= S_ARM_DIV2;
               end
            end
            S_ARM_DIV2: begin
               if (div_rsp.done) begin
                  armed_ff[id_ff] <= 1'b1;
                  state_ff        <= S_RESULT;
               end
            end
            S_RESULT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= res_kind_ff;
                  rsp_id_ff    <= '0;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

[sv/ctw_checker.sv]
// Port-level checks of the connection timing wheel, bound to the top level.
`timescale 1ns / 1ps
`include "connection_timing_wheel_assert.svh"
module ctw_checker import ctw_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [1:0]      rsp_kind,
   input logic [ID_W-1:0] rsp_expired_id,
   input logic            rsp_last
);

   // A stalled result word holds its value.
   `CTW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_expired_id) && $stable(rsp_last))

   // Only an expiry word names a connection or leaves more words to come.
   `CTW_ASSERT_NOW(a_single_word, clock, reset, rsp_valid && (rsp_kind != KIND_EXPIRED), rsp_last && (rsp_expired_id == '0))

   // While more expiry words are owed, no new input word is taken.
   `CTW_ASSERT_NOW(a_tick_busy, clock, reset, rsp_valid && !rsp_last, !req_ready)

   // An accepted input word keeps the block busy in the next cycle.
   `CTW_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind connection_timing_wheel ctw_checker u_ctw_checker (.*);
